### src/mpct_pkg.sv
`default_nettype none

package mpct_pkg;

    localparam int BYTE_BITS       = 8;
    localparam int BUTTON_BITS     = 3;
    localparam int MOVE_X_BITS     = 9;
    localparam int MOVE_Y_BITS     = 10;
    localparam int CURSOR_OUT_BITS = 12;
    localparam int SCREEN_BITS     = 12;
    localparam int CFG_INDEX_BITS  = 1;

    localparam int DEF_CURSOR_WIDTH  = 16;
    localparam int DEF_CURSOR_HEIGHT = 16;
    localparam int DEF_POSITION_BITS = 12;

    localparam logic [BYTE_BITS-1:0]   ACK_BYTE     = 8'hFA;
    localparam int                     XSIGN_POS    = 4;
    localparam int                     YSIGN_POS    = 5;
    localparam logic [SCREEN_BITS-1:0] SCREEN_W_RST = 12'd320;
    localparam logic [SCREEN_BITS-1:0] SCREEN_H_RST = 12'd200;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

    // Packet framing: wait for the acknowledge, then cycle through three bytes.
    typedef enum logic [1:0] {
        PH_WAIT_ACK,
        PH_BYTE0,
        PH_BYTE1,
        PH_BYTE2
    } phase_t;

endpackage

`default_nettype wire

### src/mpct_byte_reg.sv
`default_nettype none

module mpct_byte_reg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [mpct_pkg::BYTE_BITS-1:0] s_raw_byte,
    input  wire logic                          take,
    output logic                               byte_valid,
    output logic [mpct_pkg::BYTE_BITS-1:0]     byte_data
);

    logic                           valid_reg, valid_next;
    logic [mpct_pkg::BYTE_BITS-1:0] data_reg, data_next;

    // Refill whenever the held word is empty or leaves this cycle.
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (s_ready) begin
            valid_next = s_valid;
            data_next  = s_raw_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

`default_nettype wire

### src/mpct_axis_clamp.sv
`default_nettype none

module mpct_axis_clamp #(
    parameter int CURSOR_SIZE   = mpct_pkg::DEF_CURSOR_WIDTH,
    parameter int POSITION_BITS = mpct_pkg::DEF_POSITION_BITS
) (
    input  wire logic [POSITION_BITS-1:0]            pos_in,
    input  wire logic signed [mpct_pkg::MOVE_Y_BITS-1:0] delta,
    input  wire logic [mpct_pkg::SCREEN_BITS-1:0]    screen,
    output logic [POSITION_BITS-1:0]                 pos_out
);

    localparam int BASE = (POSITION_BITS > mpct_pkg::SCREEN_BITS) ?
                          POSITION_BITS : mpct_pkg::SCREEN_BITS;
    localparam int SW   = BASE + 2;
    localparam int DW   = mpct_pkg::MOVE_Y_BITS;

    localparam logic signed [SW-1:0] CSIZE_S = SW'(CURSOR_SIZE);
    localparam logic signed [SW-1:0] PMAX_S  = SW'((1 << POSITION_BITS) - 1);

    logic signed [SW-1:0] lim_raw;
    logic signed [SW-1:0] lim;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] res;

    always_comb begin
        lim_raw = $signed({{(SW-mpct_pkg::SCREEN_BITS){1'b0}}, screen}) - CSIZE_S;
        // upper bound saturates at zero and at the position range
        if (lim_raw < 0) begin
            lim = '0;
        end else if (lim_raw > PMAX_S) begin
            lim = PMAX_S;
        end else begin
            lim = lim_raw;
        end
        sum = $signed({{(SW-POSITION_BITS){1'b0}}, pos_in})
            + $signed({{(SW-DW){delta[DW-1]}}, delta});
        if (sum < 0) begin
            res = '0;
        end else if (sum > lim) begin
            res = lim;
        end else begin
            res = sum;
        end
        pos_out = res[POSITION_BITS-1:0];
    end

endmodule

`default_nettype wire

### src/mpct_packet_fsm.sv
`default_nettype none

module mpct_packet_fsm #(
    parameter int CURSOR_WIDTH  = mpct_pkg::DEF_CURSOR_WIDTH,
    parameter int CURSOR_HEIGHT = mpct_pkg::DEF_CURSOR_HEIGHT,
    parameter int POSITION_BITS = mpct_pkg::DEF_POSITION_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 byte_valid,
    input  wire logic [mpct_pkg::BYTE_BITS-1:0]       byte_data,
    output logic                                      take,
    input  wire logic [mpct_pkg::SCREEN_BITS-1:0]     screen_w,
    input  wire logic [mpct_pkg::SCREEN_BITS-1:0]     screen_h,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [mpct_pkg::BUTTON_BITS-1:0]          m_buttons,
    output logic signed [mpct_pkg::MOVE_X_BITS-1:0]   m_move_x,
    output logic signed [mpct_pkg::MOVE_Y_BITS-1:0]   m_move_y,
    output logic [mpct_pkg::CURSOR_OUT_BITS-1:0]      m_cursor_x,
    output logic [mpct_pkg::CURSOR_OUT_BITS-1:0]      m_cursor_y
);

    localparam int BB  = mpct_pkg::BYTE_BITS;
    localparam int XB  = mpct_pkg::MOVE_X_BITS;
    localparam int YB  = mpct_pkg::MOVE_Y_BITS;
    localparam int OB  = mpct_pkg::CURSOR_OUT_BITS;
    localparam int SB  = mpct_pkg::SCREEN_BITS;
    localparam int PB  = POSITION_BITS;
    localparam int EW  = ((PB > SB) ? PB : SB) + 2;

    mpct_pkg::phase_t phase_reg, phase_next;

    logic [BB-1:0]          first_reg, first_next;
    logic [BB-1:0]          second_reg, second_next;
    logic [PB-1:0]          pos_x_reg, pos_x_next;
    logic [PB-1:0]          pos_y_reg, pos_y_next;
    logic                   out_valid_reg, out_valid_next;
    logic [mpct_pkg::BUTTON_BITS-1:0] buttons_reg, buttons_next;
    logic signed [XB-1:0]   move_x_reg, move_x_next;
    logic signed [YB-1:0]   move_y_reg, move_y_next;
    logic [OB-1:0]          cur_x_reg, cur_x_next;
    logic [OB-1:0]          cur_y_reg, cur_y_next;

    logic                   step;
    logic signed [XB-1:0]   dx;
    logic signed [XB-1:0]   y_raw;
    logic signed [YB-1:0]   dy;
    logic signed [YB-1:0]   dx_wide;
    logic [PB-1:0]          clamp_x, clamp_y;
    logic [EW-1:0]          half_w, half_h;
    logic [EW-1:0]          clamp_x_ext, clamp_y_ext;

    // Advance while the result register is free or being drained.
    assign take = !out_valid_reg || m_ready;
    assign step = byte_valid && take;

    assign dx      = $signed({first_reg[mpct_pkg::XSIGN_POS], second_reg});
    assign y_raw   = $signed({first_reg[mpct_pkg::YSIGN_POS], byte_data});
    assign dy      = YB'(0) - $signed({y_raw[XB-1], y_raw});
    assign dx_wide = $signed({dx[XB-1], dx});

    assign half_w  = EW'(screen_w >> 1);
    assign half_h  = EW'(screen_h >> 1);

    mpct_axis_clamp #(
        .CURSOR_SIZE   (CURSOR_WIDTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_clamp_x (
        .pos_in  (pos_x_reg),
        .delta   (dx_wide),
        .screen  (screen_w),
        .pos_out (clamp_x)
    );

    mpct_axis_clamp #(
        .CURSOR_SIZE   (CURSOR_HEIGHT),
        .POSITION_BITS (POSITION_BITS)
    ) u_clamp_y (
        .pos_in  (pos_y_reg),
        .delta   (dy),
        .screen  (screen_h),
        .pos_out (clamp_y)
    );

    assign clamp_x_ext = EW'(clamp_x);
    assign clamp_y_ext = EW'(clamp_y);

    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            unique case (phase_reg)
                mpct_pkg::PH_WAIT_ACK: begin
                    if (byte_data == mpct_pkg::ACK_BYTE) begin
                        phase_next = mpct_pkg::PH_BYTE0;
                    end
                end
                mpct_pkg::PH_BYTE0: phase_next = mpct_pkg::PH_BYTE1;
                mpct_pkg::PH_BYTE1: phase_next = mpct_pkg::PH_BYTE2;
                mpct_pkg::PH_BYTE2: phase_next = mpct_pkg::PH_BYTE0;
                default:            phase_next = mpct_pkg::PH_WAIT_ACK;
            endcase
        end
    end

    always_comb begin
        first_next     = first_reg;
        second_next    = second_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        out_valid_next = take ? 1'b0 : out_valid_reg;
        buttons_next   = buttons_reg;
        move_x_next    = move_x_reg;
        move_y_next    = move_y_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        if (step) begin
            unique case (phase_reg)
                mpct_pkg::PH_WAIT_ACK: begin
                    if (byte_data == mpct_pkg::ACK_BYTE) begin
                        pos_x_next = half_w[PB-1:0];
                        pos_y_next = half_h[PB-1:0];
                    end
                end
                mpct_pkg::PH_BYTE0: first_next  = byte_data;
                mpct_pkg::PH_BYTE1: second_next = byte_data;
                mpct_pkg::PH_BYTE2: begin
                    pos_x_next     = clamp_x;
                    pos_y_next     = clamp_y;
                    out_valid_next = 1'b1;
                    buttons_next   = first_reg[mpct_pkg::BUTTON_BITS-1:0];
                    move_x_next    = dx;
                    move_y_next    = dy;
                    cur_x_next     = clamp_x_ext[OB-1:0];
                    cur_y_next     = clamp_y_ext[OB-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= mpct_pkg::PH_WAIT_ACK;
            out_valid_reg <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
        end else begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
        end
        buttons_reg <= buttons_next;
        move_x_reg  <= move_x_next;
        move_y_reg  <= move_y_next;
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_buttons  = buttons_reg;
    assign m_move_x   = move_x_reg;
    assign m_move_y   = move_y_reg;
    assign m_cursor_x = cur_x_reg;
    assign m_cursor_y = cur_y_reg;

endmodule

`default_nettype wire

### src/mouse_packet_cursor_tracker_core.sv
`default_nettype none

// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+------------------------------------------
// s_      | in        | s_valid / s_ready  | s_raw_byte
// m_      | out       | m_valid / m_ready  | m_buttons, m_move_x, m_move_y,
//         |           |                    | m_cursor_x, m_cursor_y
// cfg_    | in        | cfg_wr_en          | cfg_index, cfg_wdata
//
// One word is taken per cycle while s_ready is high. An accepted byte waits in the
// input register, and the packet logic writes the result register from it when take
// is high, so a result passes through the input register and then the result register;
// the position feedback is registered.
// Reset is synchronous on aresetn low: the block waits for the acknowledge again and
// the screen size returns to 320 x 200.
// A stalled result holds the packet logic; the input register still takes one more
// word if it is empty, then s_ready drops until m_ready frees the result register.

module mouse_packet_cursor_tracker_core #(
    parameter int CURSOR_WIDTH  = mpct_pkg::DEF_CURSOR_WIDTH,
    parameter int CURSOR_HEIGHT = mpct_pkg::DEF_CURSOR_HEIGHT,
    parameter int POSITION_BITS = mpct_pkg::DEF_POSITION_BITS
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // configuration write port
    input  wire logic                                    cfg_wr_en,
    input  wire logic [mpct_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [mpct_pkg::SCREEN_BITS-1:0]        cfg_wdata,
    // raw bytes from the mouse
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic [mpct_pkg::BYTE_BITS-1:0]          s_raw_byte,
    // decoded packets
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic [mpct_pkg::BUTTON_BITS-1:0]             m_buttons,
    output logic signed [mpct_pkg::MOVE_X_BITS-1:0]      m_move_x,
    output logic signed [mpct_pkg::MOVE_Y_BITS-1:0]      m_move_y,
    output logic [mpct_pkg::CURSOR_OUT_BITS-1:0]         m_cursor_x,
    output logic [mpct_pkg::CURSOR_OUT_BITS-1:0]         m_cursor_y
);

    logic [mpct_pkg::SCREEN_BITS-1:0] screen_w_reg, screen_w_next;
    logic [mpct_pkg::SCREEN_BITS-1:0] screen_h_reg, screen_h_next;

    logic                             byte_valid;
    logic [mpct_pkg::BYTE_BITS-1:0]   byte_data;
    logic                             take;

    // Screen size registers: decode the index and update on the write enable.
    always_comb begin
        screen_w_next = screen_w_reg;
        screen_h_next = screen_h_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                mpct_pkg::REG_SCREEN_WIDTH:  screen_w_next = cfg_wdata;
                mpct_pkg::REG_SCREEN_HEIGHT: screen_h_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_w_reg <= mpct_pkg::SCREEN_W_RST;
            screen_h_reg <= mpct_pkg::SCREEN_H_RST;
        end else begin
            screen_w_reg <= screen_w_next;
            screen_h_reg <= screen_h_next;
        end
    end

    // Input register: parts the byte stream from the packet logic.
    mpct_byte_reg u_byte_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_raw_byte (s_raw_byte),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    // Framing, sign extension, cursor clamp and the result register.
    mpct_packet_fsm #(
        .CURSOR_WIDTH  (CURSOR_WIDTH),
        .CURSOR_HEIGHT (CURSOR_HEIGHT),
        .POSITION_BITS (POSITION_BITS)
    ) u_packet_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .take       (take),
        .screen_w   (screen_w_reg),
        .screen_h   (screen_h_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_buttons  (m_buttons),
        .m_move_x   (m_move_x),
        .m_move_y   (m_move_y),
        .m_cursor_x (m_cursor_x),
        .m_cursor_y (m_cursor_y)
    );

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mpct_pkg::*;

    // Run shape
    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 12;
    localparam int SEGMENTS       = 6;
    localparam int ITEMS_PER_SEG  = 246;
    localparam int SETTLE_CYCLES  = 8;
    localparam int STALL_AFTER    = 60;
    localparam int STALL_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIR_ROWS       = 25;

    // Cursor geometry as the block is built
    localparam int CUR_W   = DEF_CURSOR_WIDTH;
    localparam int CUR_H   = DEF_CURSOR_HEIGHT;
    localparam int POS_MAX = (1 << DEF_POSITION_BITS) - 1;

    typedef struct packed {
        logic [BUTTON_BITS-1:0]        buttons;
        logic signed [MOVE_X_BITS-1:0] move_x;
        logic signed [MOVE_Y_BITS-1:0] move_y;
        logic [CURSOR_OUT_BITS-1:0]    cursor_x;
        logic [CURSOR_OUT_BITS-1:0]    cursor_y;
    } packet_t;

    // One directed row: the byte, and a hand-written packet where chk is set
    typedef struct packed {
        logic [BYTE_BITS-1:0] raw;
        logic                 chk;
        packet_t              pkt;
    } dir_row_t;

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0]         cfg_index;
    logic [SCREEN_BITS-1:0]            cfg_wdata;
    logic                              s_valid;
    logic                              s_ready;
    logic [BYTE_BITS-1:0]              s_raw_byte;
    logic                              m_valid;
    logic                              m_ready;
    logic [BUTTON_BITS-1:0]            m_buttons;
    logic signed [MOVE_X_BITS-1:0]     m_move_x;
    logic signed [MOVE_Y_BITS-1:0]     m_move_y;
    logic [CURSOR_OUT_BITS-1:0]        m_cursor_x;
    logic [CURSOR_OUT_BITS-1:0]        m_cursor_y;

    mouse_packet_cursor_tracker_core uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_raw_byte (s_raw_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_buttons  (m_buttons),
        .m_move_x   (m_move_x),
        .m_move_y   (m_move_y),
        .m_cursor_x (m_cursor_x),
        .m_cursor_y (m_cursor_y)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Tracker copy: framing, kept bytes, cursor and screen size
    phase_t               trk_phase;
    logic [BYTE_BITS-1:0] head_byte;
    logic [BYTE_BITS-1:0] dx_byte;
    logic [11:0]          trk_pos_x;
    logic [11:0]          trk_pos_y;
    logic [11:0]          scr_w;
    logic [11:0]          scr_h;

    packet_t  packet_q[$];
    int       errors = 0;
    int       words_sent = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       quiet_cycles = 0;

    dir_row_t    dir_tab [DIR_ROWS];
    logic [11:0] seg_w [SEGMENTS];
    logic [11:0] seg_h [SEGMENTS];

    // Add the motion and pin the cursor into 0 .. screen minus cursor size
    function automatic logic [11:0] clamp_pos(input logic [11:0] pos, input int delta,
                                              input logic [11:0] screen, input int csize);
        int lim;
        int v;
        lim = int'(screen) - csize;
        v = int'(pos) + delta;
        if (lim < 0) lim = 0;
        if (lim > POS_MAX) lim = POS_MAX;
        if (v < 0) v = 0;
        if (v > lim) v = lim;
        return v[11:0];
    endfunction

    // Advance the tracker by one byte; return 1 when a packet completes
    function automatic bit track_byte(input logic [BYTE_BITS-1:0] b, output packet_t pkt);
        int dx;
        int dy;
        pkt = '0;
        if (trk_phase == PH_WAIT_ACK) begin
            // Arm on the acknowledge and center the cursor, no clamp
            if (b == ACK_BYTE) begin
                trk_phase = PH_BYTE0;
                trk_pos_x = scr_w >> 1;
                trk_pos_y = scr_h >> 1;
            end
            return 1'b0;
        end
        if (trk_phase == PH_BYTE1) begin
            dx_byte   = b;
            trk_phase = PH_BYTE2;
            return 1'b0;
        end
        if (trk_phase != PH_BYTE2) begin
            head_byte = b;
            trk_phase = PH_BYTE1;
            return 1'b0;
        end
        // Third byte: sign-extend both motions, flip Y to screen-down
        trk_phase = PH_BYTE0;
        dx = int'(dx_byte);
        if (head_byte[XSIGN_POS]) dx -= 256;
        dy = int'(b);
        if (head_byte[YSIGN_POS]) dy -= 256;
        dy = -dy;
        trk_pos_x = clamp_pos(trk_pos_x, dx, scr_w, CUR_W);
        trk_pos_y = clamp_pos(trk_pos_y, dy, scr_h, CUR_H);
        pkt.buttons  = head_byte[BUTTON_BITS-1:0];
        pkt.move_x   = dx[MOVE_X_BITS-1:0];
        pkt.move_y   = dy[MOVE_Y_BITS-1:0];
        pkt.cursor_x = trk_pos_x;
        pkt.cursor_y = trk_pos_y;
        return 1'b1;
    endfunction

    // Lean on the corner values, with plain random bytes in between
    function automatic logic [BYTE_BITS-1:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return ACK_BYTE;
            3:       return 8'h80;
            4:       return 8'h7F;
            default: return BYTE_BITS'($urandom);
        endcase
    endfunction

    // Offer one word; called and returns at a falling edge
    task automatic push_byte(input logic [BYTE_BITS-1:0] b, input logic chk,
                             input packet_t typed);
        packet_t pkt;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_raw_byte <= b;
        // Hold the word until the edge that takes it
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (track_byte(b, pkt)) packet_q.push_back(chk ? typed : pkt);
        @(negedge aclk);
    endtask

    // Stop offering, let every pending packet out, then give the block time to settle
    task automatic drain();
        s_valid <= 1'b0;
        while (packet_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_screen(input logic [11:0] w, input logic [11:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SCREEN_WIDTH;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_index <= REG_SCREEN_HEIGHT;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        scr_w = w;
        scr_h = h;
    endtask

    task automatic cmp_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // Result checker: match every accepted packet against the oldest pending one
    always @(posedge aclk) begin : check_results
        packet_t want;
        if (aresetn && m_valid && m_ready) begin
            if (packet_q.size() == 0) begin
                $error("packet: none pending, actual buttons %0d move_x %0d move_y %0d",
                       m_buttons, m_move_x, m_move_y);
                errors++;
            end else begin
                want = packet_q.pop_front();
                cmp_field("buttons", want.buttons, m_buttons);
                cmp_field("move_x", $signed(want.move_x), $signed(m_move_x));
                cmp_field("move_y", $signed(want.move_y), $signed(m_move_y));
                cmp_field("cursor_x", want.cursor_x, m_cursor_x);
                cmp_field("cursor_y", want.cursor_y, m_cursor_y);
            end
        end
    end

    // Watchdog: end the run after too long without any word moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("mouse_packet_cursor_tracker_core test failed");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off so the input side fills
    initial begin : receiver
        int  stall_left;
        bit  stall_done;
        stall_left = 0;
        stall_done = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!stall_done && words_sent >= STALL_AFTER) begin
                stall_left = STALL_CYCLES;
                stall_done = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_SCREEN_WIDTH;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_raw_byte = '0;

        trk_phase = PH_WAIT_ACK;
        head_byte = '0;
        dx_byte   = '0;
        trk_pos_x = '0;
        trk_pos_y = '0;
        scr_w     = SCREEN_W_RST;
        scr_h     = SCREEN_H_RST;

        // Directed bytes at the reset screen of 320 x 200 (cursor range 304 x 184)
        dir_tab = '{
            // ignored while waiting for the acknowledge
            '{8'h00, 1'b0, '{0, 0, 0, 0, 0}},
            '{8'hFF, 1'b0, '{0, 0, 0, 0, 0}},
            '{8'hFB, 1'b0, '{0, 0, 0, 0, 0}},
            '{8'hF9, 1'b0, '{0, 0, 0, 0, 0}},
            // arm: cursor goes to the center
            '{ACK_BYTE, 1'b0, '{0, 0, 0, 0, 0}},
            // still packet: cursor stays at the center
            '{8'h00, 1'b0, '{0, 0, 0, 0, 0}},
            '{8'h00, 1'b0, '{0, 0, 0, 0, 0}},
            '{8'h00, 1'b1, '{3'd0, 9'sd0, 10'sd0, 12'd160, 12'd100}},
            // all buttons, an acknowledge taken as X data, X pinned at the right edge
            '{8'h07, 1'b0, '{0, 0, 0, 0, 0}},
            '{ACK_BYTE, 1'b0, '{0, 0, 0, 0, 0}},
            '{8'h01, 1'b1, '{3'd7, 9'sd250, -10'sd1, 12'd304, 12'd99}},
            // both signs, largest negative bytes: Y pinned at the bottom
            '{8'h30, 1'b0, '{0, 0, 0, 0, 0}},
            '{8'h00, 1'b0, '{0, 0, 0, 0, 0}},
            '{8'h00, 1'b1, '{3'd0, -9'sd256, 10'sd256, 12'd48, 12'd184}},
            // both axes driven below zero
            '{8'h10, 1'b0, '{0, 0, 0, 0, 0}},
            '{8'h80, 1'b0, '{0, 0, 0, 0, 0}},
            '{8'hFF, 1'b1, '{3'd0, -9'sd128, -10'sd255, 12'd0, 12'd0}},
            // largest positive X, Y of minus one flipped to plus one
            '{8'h21, 1'b0, '{0, 0, 0, 0, 0}},
            '{8'hFF, 1'b0, '{0, 0, 0, 0, 0}},
            '{8'hFF, 1'b1, '{3'd1, 9'sd255, 10'sd1, 12'd255, 12'd1}},
            // every header bit set
            '{8'hFF, 1'b0, '{0, 0, 0, 0, 0}},
            '{8'hFF, 1'b0, '{0, 0, 0, 0, 0}},
            '{8'h00, 1'b1, '{3'd7, -9'sd1, 10'sd256, 12'd254, 12'd184}},
            // leave a packet half done going into the random part
            '{8'h55, 1'b0, '{0, 0, 0, 0, 0}},
            '{8'hAA, 1'b0, '{0, 0, 0, 0, 0}}
        };

        // Screen sizes per segment: extremes, at and below cursor size, random, just above cursor size
        seg_w = '{12'd4095, 12'd16, 12'd5,  12'd15,   12'd0, 12'd17};
        seg_h = '{12'd4095, 12'd16, 12'd0,  12'd4095, 12'd0, 12'd4080};
        seg_w[4] = 12'($urandom_range(16, 4095));
        seg_h[4] = 12'($urandom_range(16, 4095));

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Sender idles a quarter of the time, receiver two thirds
        send_idle_pct = 25;
        recv_idle_pct = 66;
        foreach (dir_tab[i]) push_byte(dir_tab[i].raw, dir_tab[i].chk, dir_tab[i].pkt);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            // Change the screen only with the block empty
            drain();
            write_screen(seg_w[seg], seg_h[seg]);
            if (seg < 2) begin
                send_idle_pct = 25;
                recv_idle_pct = 66;
            end else if (seg < 4) begin
                send_idle_pct = 66;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (ITEMS_PER_SEG) push_byte(pick_byte(), 1'b0, '0);
        end

        drain();
        if (errors == 0 && packet_q.size() == 0) begin
            $display("mouse_packet_cursor_tracker_core test passed");
        end else begin
            $display("mouse_packet_cursor_tracker_core test failed");
        end
        $finish;
    end

endmodule
